// ----- design/lbp_pkg.sv -----
package lbp_pkg;

  localparam int unsigned MaxDimDefault    = 256;
  localparam int unsigned PatchSize        = 16;
  localparam int unsigned NumBins          = 256;
  localparam int unsigned NumGroups        = 64;
  localparam int unsigned FifoDepth        = 4;

  localparam logic CfgWidth  = 1'b0;
  localparam logic CfgHeight = 1'b1;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncQuery = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] pixel;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  group;
    logic [16:0] bin_a;
    logic [16:0] bin_b;
    logic [16:0] bin_c;
    logic [16:0] bin_d;
    logic [8:0]  patch_pixels;
    logic        last;
  } out_item_t;

endpackage

// ----- design/lbp_ram.sv -----
module lbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/lbp_fifo.sv -----
module lbp_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lbp_pkg::in_item_t data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output lbp_pkg::in_item_t data_o
);

  localparam int unsigned Aw = $clog2(Depth);

  lbp_pkg::in_item_t buf_q [Depth];
  logic [Aw-1:0] wp_q, rp_q;
  logic [Aw:0]   cnt_q;

  assign full_o  = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      buf_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wp_q <= (wp_q == Aw'(Depth-1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rp_q <= (rp_q == Aw'(Depth-1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (Aw+1)'(push_i && !full_o) - (Aw+1)'(pop_i && !empty_o);
    end
  end

endmodule

// ----- design/lbp_divider.sv -----
// Restoring divider: (cnt << 16) / total, one quotient bit per cycle.
module lbp_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [8:0]  cnt_i,
  input  logic [8:0]  total_i,
  output logic        busy_o,
  output logic [16:0] quot_o
);

  logic [24:0] num_q;
  logic [9:0]  rem_q;
  logic [8:0]  den_q;
  logic [4:0]  step_q;
  logic [9:0]  trial;

  assign trial  = {rem_q[8:0], num_q[24]};
  assign quot_o = num_q[16:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_o <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_o <= 1'b1;
      step_q <= 5'd25;
    end else if (busy_o) begin
      step_q <= step_q - 1'b1;
      if (step_q == 5'd1) begin
        busy_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {cnt_i, 16'd0};
      rem_q <= '0;
      den_q <= total_i;
    end else if (busy_o) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        num_q <= {num_q[23:0], 1'b1};
      end else begin
        rem_q <= trial;
        num_q <= {num_q[23:0], 1'b0};
      end
    end
  end

endmodule

// ----- design/lbp_engine.sv -----
module lbp_engine #(
  parameter int unsigned MaxDim = lbp_pkg::MaxDimDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [8:0]         width_i,
  input  logic [8:0]         height_i,
  input  logic               valid_i,
  input  lbp_pkg::in_item_t  item_i,
  output logic               take_o,
  output logic               out_valid_o,
  output lbp_pkg::out_item_t out_item_o,
  input  logic               out_ready_i
);

  localparam int unsigned Cw   = $clog2(MaxDim);
  localparam int unsigned Xw   = ((Cw > 8) ? Cw : 8) + 1;
  localparam int unsigned Iw   = 2 * Cw;
  localparam int unsigned Half = lbp_pkg::PatchSize / 2;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StClear = 9'b000000010,
    StRead  = 9'b000000100,
    StWait  = 9'b000001000,
    StCode  = 9'b000010000,
    StHist  = 9'b000100000,
    StBin   = 9'b001000000,
    StDiv   = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q;
  logic [3:0]    nb_q;
  logic [7:0]    nbv_q [9];
  logic [Xw-1:0] x_q, y_q, x1_q, x2_q, y2_q;
  logic [8:0]    total_q;
  logic [7:0]    code;
  logic [7:0]    hidx_q;
  logic [1:0]    lane_q;
  logic [16:0]   bins_q [4];
  logic          div_go_q;

  logic [Xw-1:0] w_c, h_c;
  assign w_c = (width_i < 9'd3) ? Xw'(3) :
               ((32'(width_i) > MaxDim) ? Xw'(MaxDim) : Xw'(width_i));
  assign h_c = (height_i < 9'd3) ? Xw'(3) :
               ((32'(height_i) > MaxDim) ? Xw'(MaxDim) : Xw'(height_i));

  // image store
  logic          img_we;
  logic [Iw-1:0] img_waddr, img_raddr;
  logic [7:0]    img_rdata;
  logic [Xw-1:0] rx, ry;

  always_comb begin
    rx = x_q + Xw'(nb_q == 4'd2 || nb_q == 4'd3 || nb_q == 4'd4)
             - Xw'(nb_q == 4'd0 || nb_q == 4'd6 || nb_q == 4'd7);
    ry = y_q + Xw'(nb_q == 4'd4 || nb_q == 4'd5 || nb_q == 4'd6)
             - Xw'(nb_q == 4'd0 || nb_q == 4'd1 || nb_q == 4'd2);
  end

  assign img_we    = (state_q == StIdle) && valid_i && item_i.func == lbp_pkg::FuncLoad
                     && (32'(item_i.col) < MaxDim) && (32'(item_i.row) < MaxDim);
  assign img_waddr = {Cw'(item_i.row), Cw'(item_i.col)};
  assign img_raddr = {ry[Cw-1:0], rx[Cw-1:0]};

  lbp_ram #(.Width(8), .Depth(MaxDim * MaxDim)) u_img (
    .clk_i, .we_i(img_we), .waddr_i(img_waddr), .wdata_i(item_i.pixel),
    .raddr_i(img_raddr), .rdata_o(img_rdata)
  );

  // histogram store
  logic       h_we;
  logic [7:0] h_waddr, h_raddr;
  logic [8:0] h_wdata, h_rdata;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      code[7-i] = (nbv_q[i] >= nbv_q[8]);
    end
  end

  always_comb begin
    h_we = 1'b0;
    h_waddr = hidx_q;
    h_wdata = '0;
    h_raddr = code;
    unique case (state_q)
      StClear: h_we = 1'b1;
      StHist:  begin
        h_we = 1'b1;
        h_waddr = code;
        h_wdata = h_rdata + 1'b1;
      end
      StBin, StDiv: h_raddr = hidx_q;
      default: ;
    endcase
  end

  lbp_ram #(.Width(9), .Depth(lbp_pkg::NumBins)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  logic        div_start, div_busy;
  logic [16:0] div_quot;
  lbp_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .cnt_i(h_rdata), .total_i(total_q),
    .busy_o(div_busy), .quot_o(div_quot)
  );
  // bin count arrives in the cycle after StBin issues the read
  assign div_start = div_go_q && (total_q != '0);

  assign take_o      = (state_q == StIdle) && valid_i;
  assign out_valid_o = (state_q == StOut);
  always_comb begin
    out_item_o.group        = hidx_q[7:2];
    out_item_o.bin_a        = bins_q[0];
    out_item_o.bin_b        = bins_q[1];
    out_item_o.bin_c        = bins_q[2];
    out_item_o.bin_d        = bins_q[3];
    out_item_o.patch_pixels = total_q;
    out_item_o.last         = (hidx_q[7:2] == 6'd63);
  end

  logic [Xw:0] lo_x, lo_y, hi_x, hi_y;

  always_comb begin
    lo_x = (Xw+1)'(item_i.col) - (Xw+1)'(Half);
    lo_y = (Xw+1)'(item_i.row) - (Xw+1)'(Half);
    hi_x = (Xw+1)'(item_i.col) + (Xw+1)'(Half);
    hi_y = (Xw+1)'(item_i.row) + (Xw+1)'(Half);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      nb_q     <= '0;
      hidx_q   <= '0;
      lane_q   <= '0;
      total_q  <= '0;
      div_go_q <= 1'b0;
      x_q <= '0; y_q <= '0; x1_q <= '0; x2_q <= '0; y2_q <= '0;
    end else begin
      div_go_q <= (state_q == StBin);
      unique case (state_q)
        StIdle: if (valid_i && item_i.func == lbp_pkg::FuncQuery) begin
          x1_q <= (lo_x[Xw] || lo_x == '0) ? Xw'(1) : lo_x[Xw-1:0];
          y_q  <= (lo_y[Xw] || lo_y == '0) ? Xw'(1) : lo_y[Xw-1:0];
          x2_q <= (hi_x > (Xw+1)'(w_c - 2'd2)) ? w_c - 2'd2 : hi_x[Xw-1:0];
          y2_q <= (hi_y > (Xw+1)'(h_c - 2'd2)) ? h_c - 2'd2 : hi_y[Xw-1:0];
          hidx_q  <= '0;
          total_q <= '0;
          state_q <= StClear;
        end
        StClear: begin
          hidx_q <= hidx_q + 1'b1;
          if (hidx_q == 8'hFF) begin
            x_q <= x1_q;
            nb_q <= '0;
            state_q <= (x1_q < x2_q && y_q < y2_q) ? StRead : StBin;
          end
        end
        StRead: begin
          // sweep 9 addresses: 8 neighbours then centre
          nb_q <= nb_q + 1'b1;
          if (nb_q != 4'd0) nbv_q[nb_q - 1'b1] <= img_rdata;
          if (nb_q == 4'd8) state_q <= StWait;
        end
        StWait: begin
          nbv_q[8] <= img_rdata;
          state_q <= StCode;
        end
        StCode: state_q <= StHist;
        StHist: begin
          total_q <= total_q + 1'b1;
          nb_q <= '0;
          if (x_q + 1'b1 < x2_q) begin
            x_q <= x_q + 1'b1;
            state_q <= StRead;
          end else if (y_q + 1'b1 < y2_q) begin
            x_q <= x1_q;
            y_q <= y_q + 1'b1;
            state_q <= StRead;
          end else begin
            hidx_q <= '0;
            lane_q <= '0;
            state_q <= StBin;
          end
        end
        StBin: state_q <= StDiv;
        StDiv: if (!div_busy && !div_start) begin
          bins_q[lane_q] <= (total_q == '0) ? '0 : div_quot;
          lane_q <= lane_q + 1'b1;
          if (lane_q == 2'd3) begin
            state_q <= StOut;
          end else begin
            hidx_q <= hidx_q + 1'b1;
            state_q <= StBin;
          end
        end
        StOut: if (out_ready_i) begin
          lane_q <= '0;
          hidx_q <= hidx_q + 1'b1;
          state_q <= (hidx_q == 8'hFF) ? StIdle : StBin;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- design/lbp_out_fifo.sv -----
module lbp_out_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  lbp_pkg::out_item_t in_item_i,
  output logic               in_ready_o,
  input  logic               pop_i,
  output logic               empty_o,
  output lbp_pkg::out_item_t item_o
);

  lbp_pkg::out_item_t buf_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o = (cnt_q != 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign item_o     = buf_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- design/lbp_patch_histogram.sv -----
// A load is written to the image store as the engine takes it from the input queue; a query
// clears the 256 histogram entries, reads the eight neighbours and the centre of each patch
// pixel to count its code, then runs four divisions and one output for each of the 64 groups.
// Throughput: one item at a time; input queue four deep.
// Reset clears control state and sets width and height to 256; the image store is
// undefined until written.
module lbp_patch_histogram #(
  parameter int unsigned MaxDim = lbp_pkg::MaxDimDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  lbp_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output lbp_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [8:0]         cfg_data_i
);

  logic [8:0] width_q, height_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lbp_pkg::CfgWidth:  width_q  <= cfg_data_i;
        lbp_pkg::CfgHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic              q_empty, q_take;
  lbp_pkg::in_item_t q_item;

  lbp_fifo #(.Depth(lbp_pkg::FifoDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_item_i), .full_o(full),
    .pop_i(q_take), .empty_o(q_empty), .data_o(q_item)
  );

  logic               e_valid, e_ready;
  lbp_pkg::out_item_t e_item;

  lbp_engine #(.MaxDim(MaxDim)) u_engine (
    .clk_i, .rst_ni, .width_i(width_q), .height_i(height_q),
    .valid_i(!q_empty), .item_i(q_item), .take_o(q_take),
    .out_valid_o(e_valid), .out_item_o(e_item), .out_ready_i(e_ready)
  );

  lbp_out_fifo u_out (
    .clk_i, .rst_ni, .in_valid_i(e_valid), .in_item_i(e_item), .in_ready_o(e_ready),
    .pop_i(pop), .empty_o(empty), .item_o(out_item_o)
  );

  a_last_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.last) |-> (out_item_o.group == 6'd63))
    else $error("last flag on wrong group");
  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.bin_a <= 17'd65536 && out_item_o.bin_d <= 17'd65536))
    else $error("bin above one");
  a_empty_patch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.patch_pixels == '0) |-> (out_item_o.bin_a == '0))
    else $error("nonzero bin for empty patch");

endmodule

// ----- tb/tb_lbp_patch_histogram.sv -----
`timescale 1ns / 1ps

module tb_lbp_patch_histogram;

  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned SettleCycles = 64;

  typedef enum logic [1:0] {RowCfg, RowLoad, RowQuery, RowQueryEmpty} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              idx;
    logic [8:0]        data;
    lbp_pkg::in_item_t item;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  lbp_pkg::in_item_t  in_item_i = '0;
  logic               full, empty;
  logic               pop = 1'b0;
  lbp_pkg::out_item_t out_item_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic               cfg_index_i = 1'b0;
  logic [8:0]         cfg_data_i = '0;

  lbp_patch_histogram i_dut (
    .clk_i, .rst_ni, .push, .in_item_i, .full, .empty, .pop, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [7:0]         pixel_mem [0:65535];
  bit                 pixel_set [0:65535];
  logic [8:0]         width_reg = 9'd256;
  logic [8:0]         height_reg = 9'd256;
  lbp_pkg::out_item_t groups_q [$];
  int unsigned        errors = 0;
  int unsigned        cycles = 0;
  int unsigned        idle_pct = 0;
  int unsigned        stall_pct = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[lbp_patch_histogram] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // item moves at the next rising edge; outputs are stable here
  always @(negedge clk_i) begin
    lbp_pkg::out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (groups_q.size() == 0) begin
        $display("%0t unexpected item: got %p", $time, out_item_o);
        errors++;
      end else begin
        want = groups_q.pop_front();
        if (out_item_o.group !== want.group || out_item_o.bin_a !== want.bin_a ||
            out_item_o.bin_b !== want.bin_b || out_item_o.bin_c !== want.bin_c ||
            out_item_o.bin_d !== want.bin_d ||
            out_item_o.patch_pixels !== want.patch_pixels ||
            out_item_o.last !== want.last) begin
          $display("%0t mismatch: expected %p actual %p", $time, want, out_item_o);
          errors++;
        end
      end
    end
  end

  function automatic int clamp_size(logic [8:0] v);
    if (v < 3) return 3;
    if (v > 256) return 256;
    return int'(v);
  endfunction

  // patch bounds, half-open: [lo, hi)
  function automatic void patch_bounds(input int cx, input int cy,
                                       output int x1, output int y1,
                                       output int x2, output int y2);
    x1 = (cx - 8 < 1) ? 1 : cx - 8;
    y1 = (cy - 8 < 1) ? 1 : cy - 8;
    x2 = (cx + 8 > clamp_size(width_reg) - 2) ? clamp_size(width_reg) - 2 : cx + 8;
    y2 = (cy + 8 > clamp_size(height_reg) - 2) ? clamp_size(height_reg) - 2 : cy + 8;
  endfunction

  function automatic int px(int x, int y);
    return int'(pixel_mem[y * 256 + x]);
  endfunction

  function automatic void predict_descriptor(int cx, int cy);
    int unsigned hist [256];
    int x1, y1, x2, y2, c;
    logic [7:0] code;
    longint unsigned total;
    longint unsigned share [4];
    lbp_pkg::out_item_t r;
    patch_bounds(cx, cy, x1, y1, x2, y2);
    total = 0;
    foreach (hist[i]) hist[i] = 0;
    for (int y = y1; y < y2; y++) begin
      for (int x = x1; x < x2; x++) begin
        c = px(x, y);
        code = {px(x - 1, y - 1) >= c, px(x, y - 1) >= c, px(x + 1, y - 1) >= c,
                px(x + 1, y) >= c, px(x + 1, y + 1) >= c, px(x, y + 1) >= c,
                px(x - 1, y + 1) >= c, px(x - 1, y) >= c};
        hist[code]++;
        total++;
      end
    end
    for (int g = 0; g < 64; g++) begin
      for (int j = 0; j < 4; j++) begin
        share[j] = (total == 0) ? 0 : ({32'd0, hist[g * 4 + j]} << 16) / total;
      end
      r.group = g[5:0];
      r.bin_a = share[0][16:0];
      r.bin_b = share[1][16:0];
      r.bin_c = share[2][16:0];
      r.bin_d = share[3][16:0];
      r.patch_pixels = total[8:0];
      r.last = (g == 63);
      groups_q.insert(groups_q.size(), r);
    end
  endfunction

  task automatic send_item(lbp_pkg::in_item_t it);
    bit ok;
    push <= 1'b1;
    in_item_i <= it;
    do begin
      @(negedge clk_i);
      ok = !full;
      @(posedge clk_i);
    end while (!ok);
    if (it.func == lbp_pkg::FuncLoad) begin
      pixel_mem[{it.row, it.col}] = it.pixel;
      pixel_set[{it.row, it.col}] = 1'b1;
    end else begin
      predict_descriptor(it.col, it.row);
    end
    if ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] rand_pixel();
    return ($urandom_range(1)) ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  // load every pixel of the read window that was never written
  task automatic fill_window(int cx, int cy);
    int x1, y1, x2, y2;
    lbp_pkg::in_item_t ld;
    patch_bounds(cx, cy, x1, y1, x2, y2);
    if (x1 >= x2 || y1 >= y2) return;
    for (int y = y1 - 1; y <= y2; y++) begin
      for (int x = x1 - 1; x <= x2; x++) begin
        if (!pixel_set[y * 256 + x]) begin
          ld = '{func: lbp_pkg::FuncLoad, col: 8'(x), row: 8'(y), pixel: rand_pixel()};
          send_item(ld);
        end
      end
    end
  endtask

  task automatic query(int cx, int cy);
    fill_window(cx, cy);
    send_item('{func: lbp_pkg::FuncQuery, col: 8'(cx), row: 8'(cy), pixel: 8'($urandom)});
  endtask

  task automatic drain();
    push <= 1'b0;
    while (groups_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [8:0] data);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
    if (idx == lbp_pkg::CfgWidth) width_reg = data;
    else height_reg = data;
  endtask

  stim_row_t stim_tab [16] = '{
    '{RowCfg,        lbp_pkg::CfgWidth,  9'd3,   '0},
    '{RowQueryEmpty, lbp_pkg::CfgWidth,  9'd0,
      '{lbp_pkg::FuncQuery, 8'd0,   8'd0,   8'd0}},
    '{RowQueryEmpty, lbp_pkg::CfgWidth,  9'd0,
      '{lbp_pkg::FuncQuery, 8'd255, 8'd255, 8'd255}},
    '{RowCfg,        lbp_pkg::CfgWidth,  9'd0,   '0},
    '{RowQueryEmpty, lbp_pkg::CfgWidth,  9'd0,
      '{lbp_pkg::FuncQuery, 8'd128, 8'd7,   8'd0}},
    '{RowCfg,        lbp_pkg::CfgWidth,  9'd511, '0},
    '{RowCfg,        lbp_pkg::CfgHeight, 9'd2,   '0},
    '{RowQueryEmpty, lbp_pkg::CfgWidth,  9'd0,
      '{lbp_pkg::FuncQuery, 8'd5,   8'd5,   8'd0}},
    '{RowCfg,        lbp_pkg::CfgWidth,  9'd6,   '0},
    '{RowCfg,        lbp_pkg::CfgHeight, 9'd6,   '0},
    '{RowLoad,       lbp_pkg::CfgWidth,  9'd0,
      '{lbp_pkg::FuncLoad,  8'd255, 8'd255, 8'd255}},
    '{RowLoad,       lbp_pkg::CfgWidth,  9'd0,
      '{lbp_pkg::FuncLoad,  8'd0,   8'd0,   8'd0}},
    '{RowLoad,       lbp_pkg::CfgWidth,  9'd0,
      '{lbp_pkg::FuncLoad,  8'd1,   8'd1,   8'd255}},
    '{RowQuery,      lbp_pkg::CfgWidth,  9'd0,
      '{lbp_pkg::FuncQuery, 8'd1,   8'd1,   8'd0}},
    '{RowQuery,      lbp_pkg::CfgWidth,  9'd0,
      '{lbp_pkg::FuncQuery, 8'd0,   8'd0,   8'd0}},
    '{RowQueryEmpty, lbp_pkg::CfgWidth,  9'd0,
      '{lbp_pkg::FuncQuery, 8'd12,  8'd12,  8'd0}}
  };

  int unsigned anchors [6] = '{0, 1, 3, 5, 9, 255};
  int unsigned phase_w [4] = '{6, 8, 7, 3};
  int unsigned phase_h [4] = '{6, 8, 5, 200};
  int unsigned phase_idle [4] = '{0, 52, 0, 18};
  int unsigned phase_stall [4] = '{0, 0, 52, 18};

  initial begin
    int cx, cy;
    lbp_pkg::out_item_t z;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_tab[i]) begin
      case (stim_tab[i].kind)
        RowCfg: begin
          drain();
          write_reg(stim_tab[i].idx, stim_tab[i].data);
        end
        RowLoad: send_item(stim_tab[i].item);
        RowQuery: query(stim_tab[i].item.col, stim_tab[i].item.row);
        RowQueryEmpty: begin
          send_item(stim_tab[i].item);
          // patch clips to nothing: drop the computed groups, type them in
          repeat (64) void'(groups_q.pop_back());
          for (int g = 0; g < 64; g++) begin
            z = '0;
            z.group = g[5:0];
            z.last = (g == 63);
            groups_q.insert(groups_q.size(), z);
          end
        end
        default: ;
      endcase
    end

    for (int p = 0; p < 4; p++) begin
      drain();
      write_reg(lbp_pkg::CfgWidth, 9'(phase_w[p]));
      write_reg(lbp_pkg::CfgHeight, 9'(phase_h[p]));
      idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < 18; n++) begin
        if (p == 2 && n == 8) drain();
        if ($urandom_range(99) < 60) begin
          if ($urandom_range(1)) begin
            send_item('{func: lbp_pkg::FuncLoad, col: 8'($urandom_range(7)),
                        row: 8'($urandom_range(7)), pixel: rand_pixel()});
          end else begin
            send_item('{func: lbp_pkg::FuncLoad, col: 8'($urandom), row: 8'($urandom),
                        pixel: rand_pixel()});
          end
        end else begin
          if ($urandom_range(99) < 75) begin
            cx = anchors[$urandom_range(5)] + $urandom_range(0, 3) - 1;
            cy = anchors[$urandom_range(5)] + $urandom_range(0, 3) - 1;
            cx = (cx < 0) ? 0 : (cx > 255) ? 255 : cx;
            cy = (cy < 0) ? 0 : (cy > 255) ? 255 : cy;
          end else begin
            cx = $urandom_range(255);
            cy = $urandom_range(255);
          end
          query(cx, cy);
        end
      end
    end

    push <= 1'b0;
    while (groups_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("[lbp_patch_histogram] OK");
    end else begin
      $display("[lbp_patch_histogram] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/lbp_pkg.sv
design/lbp_ram.sv
design/lbp_fifo.sv
design/lbp_divider.sv
design/lbp_engine.sv
design/lbp_out_fifo.sv
design/lbp_patch_histogram.sv
tb/tb_lbp_patch_histogram.sv
